// ===== design/srqe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srqe_pkg
// Shared types, codes and sizes of the sensor ring query engine.
// ----------------------------------------------------------------------------
package srqe_pkg;

    localparam int RING_DEPTH = 11;
    localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int DIV_STEPS  = 32;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        CMD_SAMPLE_A = 2'd0,
        CMD_SAMPLE_B = 2'd1,
        CMD_SAMPLE_C = 2'd2,
        CMD_REQUEST  = 2'd3
    } command_t;

    localparam logic [7:0] CODE_NEWEST_A = 8'hA0;
    localparam logic [7:0] CODE_NEWEST_B = 8'hA1;
    localparam logic [7:0] CODE_NEWEST_C = 8'hA2;
    localparam logic [7:0] CODE_MEAN_A   = 8'hA3;
    localparam logic [7:0] CODE_MEAN_B   = 8'hA4;
    localparam logic [7:0] CODE_MEAN_C   = 8'hA5;

    typedef enum logic [1:0] {
        RING_A = 2'd0,
        RING_B = 2'd1,
        RING_C = 2'd2
    } ring_sel_t;

    typedef enum logic [1:0] {
        SRC_ZERO   = 2'd0,
        SRC_NEWEST = 2'd1,
        SRC_QUOT   = 2'd2
    } out_src_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] sample_value;
        logic [7:0]  request_code;
    } req_word_t;

    typedef struct packed {
        logic [7:0]  echoed_code;
        logic [31:0] payload;
        logic        known_request;
    } rsp_word_t;

    typedef struct packed {
        logic     sample_wr;
        logic     load_req;
        logic     rd_newest;
        logic     rd_walk;
        logic     acc;
        logic     div_load;
        logic     div_step;
        logic     out_load;
        out_src_t out_src;
    } ctl_cmd_t;

    typedef struct packed {
        logic known;
        logic is_mean;
        logic rd_zero;
        logic cnt_zero;
        logic cnt_last;
        logic div_last;
    } dp_status_t;

endpackage

// ===== design/sensor_ring_query_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_ring_query_engine_unit
// Three sample rings answering newest-sample and truncated-mean requests.
// ----------------------------------------------------------------------------
//  channel | valid      | stall      | word
//  request | req_valid  | req_stall  | req_word (command, sample_value, request_code)
//  result  | rsp_valid  | rsp_stall  | rsp_word (echoed_code, payload, known_request)
//
//  Sample word: written when accepted, no result, next word accepted right after.
//  Unknown code: result offered from DECODE with no ring read; newest sample: after a ring read.
//  Mean: a CHECK and a READ state per ring entry walked, then a 32-step radix-2 divider.
//  Reset clears rings through per-entry valid bits; no clearing pass.
//  Requests hold req_stall high until the result word is taken.
// ----------------------------------------------------------------------------
module sensor_ring_query_engine_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  srqe_pkg::req_word_t req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output srqe_pkg::rsp_word_t rsp_word
);

    srqe_pkg::ctl_cmd_t   cmd;
    srqe_pkg::dp_status_t status;
    logic                 req_is_request;

    assign req_is_request = (srqe_pkg::command_t'(req_word.command) == srqe_pkg::CMD_REQUEST);

    srqe_controller u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_is_request (req_is_request),
        .req_stall      (req_stall),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .cmd            (cmd),
        .status         (status)
    );

    srqe_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_word (req_word),
        .cmd      (cmd),
        .status   (status),
        .rsp_word (rsp_word)
    );

`ifndef SYNTHESIS
    a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall)
        else $error("request accepted while result pending");

    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_word.known_request) |-> (rsp_word.payload == 32'd0))
        else $error("unknown code with nonzero payload");

    a_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req_is_request) |=> req_stall)
        else $error("not busy after request");
`endif

endmodule

// ===== design/srqe_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srqe_datapath
// Sample rings, read port, mean accumulator, radix-2 divider, result register.
// ----------------------------------------------------------------------------
module srqe_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  srqe_pkg::req_word_t req_word,
    input  srqe_pkg::ctl_cmd_t  cmd,
    output srqe_pkg::dp_status_t status,
    output srqe_pkg::rsp_word_t rsp_word
);

    logic [7:0]  ring_a_mem [srqe_pkg::RING_DEPTH];
    logic [7:0]  ring_b_mem [srqe_pkg::RING_DEPTH];
    logic [31:0] ring_c_mem [srqe_pkg::RING_DEPTH];

    logic [srqe_pkg::RING_DEPTH-1:0] valid_a_reg, valid_b_reg, valid_c_reg;
    logic [srqe_pkg::IDX_W-1:0]      widx_a_reg, widx_b_reg, widx_c_reg;

    logic [7:0]  rdata_a_reg, rdata_b_reg;
    logic [31:0] rdata_c_reg;
    logic        rvalid_a_reg, rvalid_b_reg, rvalid_c_reg;

    logic [7:0]                 code_reg;
    srqe_pkg::ring_sel_t        sel_reg;
    logic                       known_reg;
    logic                       mean_reg;
    logic [31:0]                sum_reg;
    logic [srqe_pkg::CNT_W-1:0] cnt_reg;
    logic [31:0]                quo_reg;
    logic [srqe_pkg::CNT_W-1:0] rem_reg;
    logic [srqe_pkg::STEP_W-1:0] step_reg;
    srqe_pkg::rsp_word_t        rsp_reg;

    logic [srqe_pkg::IDX_W-1:0] widx_sel;
    logic [srqe_pkg::IDX_W-1:0] newest_idx;
    logic [srqe_pkg::IDX_W-1:0] rd_addr;
    logic [31:0]                rd_value;
    logic [7:0]                 code_in;
    logic                       known_in;
    logic                       mean_in;
    logic [7:0]                 sel_off;
    logic [srqe_pkg::CNT_W:0]   rem_sh;
    logic                       fits;

    function automatic logic [srqe_pkg::IDX_W-1:0] advance(
        input logic [srqe_pkg::IDX_W-1:0] idx
    );
        logic [srqe_pkg::IDX_W-1:0] r;
        if (idx == srqe_pkg::IDX_W'(srqe_pkg::RING_DEPTH - 1))
            r = '0;
        else
            r = idx + srqe_pkg::IDX_W'(1);
        return r;
    endfunction

    assign code_in  = req_word.request_code;
    assign known_in = (code_in >= srqe_pkg::CODE_NEWEST_A) && (code_in <= srqe_pkg::CODE_MEAN_C);
    assign mean_in  = (code_in >= srqe_pkg::CODE_MEAN_A);
    assign sel_off  = mean_in ? (code_in - srqe_pkg::CODE_MEAN_A)
                              : (code_in - srqe_pkg::CODE_NEWEST_A);

    always_comb
    begin
        case (sel_reg)
            srqe_pkg::RING_A: widx_sel = widx_a_reg;
            srqe_pkg::RING_B: widx_sel = widx_b_reg;
            srqe_pkg::RING_C: widx_sel = widx_c_reg;
            default:          widx_sel = widx_c_reg;
        endcase
    end

    assign newest_idx = (widx_sel == '0) ? srqe_pkg::IDX_W'(srqe_pkg::RING_DEPTH - 1)
                                         : widx_sel - srqe_pkg::IDX_W'(1);
    assign rd_addr    = cmd.rd_newest ? newest_idx : cnt_reg[srqe_pkg::IDX_W-1:0];

    always_comb
    begin
        case (sel_reg)
            srqe_pkg::RING_A: rd_value = rvalid_a_reg ? {24'd0, rdata_a_reg} : 32'd0;
            srqe_pkg::RING_B: rd_value = rvalid_b_reg ? {24'd0, rdata_b_reg} : 32'd0;
            srqe_pkg::RING_C: rd_value = rvalid_c_reg ? rdata_c_reg : 32'd0;
            default:          rd_value = 32'd0;
        endcase
    end

    assign rem_sh = {rem_reg, quo_reg[31]};
    assign fits   = (rem_sh >= {1'b0, cnt_reg});

    // ring storage
    always_ff @(posedge clk)
    begin
        if (cmd.sample_wr)
        begin
            case (srqe_pkg::command_t'(req_word.command))
                srqe_pkg::CMD_SAMPLE_A: ring_a_mem[widx_a_reg] <= req_word.sample_value[7:0];
                srqe_pkg::CMD_SAMPLE_B: ring_b_mem[widx_b_reg] <= req_word.sample_value[7:0];
                srqe_pkg::CMD_SAMPLE_C: ring_c_mem[widx_c_reg] <= req_word.sample_value;
                default: ;
            endcase
        end
        if (cmd.rd_newest || cmd.rd_walk)
        begin
            rdata_a_reg <= ring_a_mem[rd_addr];
            rdata_b_reg <= ring_b_mem[rd_addr];
            rdata_c_reg <= ring_c_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg  <= '0;
            valid_b_reg  <= '0;
            valid_c_reg  <= '0;
            widx_a_reg   <= '0;
            widx_b_reg   <= '0;
            widx_c_reg   <= '0;
            rvalid_a_reg <= 1'b0;
            rvalid_b_reg <= 1'b0;
            rvalid_c_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sample_wr)
            begin
                case (srqe_pkg::command_t'(req_word.command))
                    srqe_pkg::CMD_SAMPLE_A:
                    begin
                        valid_a_reg[widx_a_reg] <= 1'b1;
                        widx_a_reg              <= advance(widx_a_reg);
                    end
                    srqe_pkg::CMD_SAMPLE_B:
                    begin
                        valid_b_reg[widx_b_reg] <= 1'b1;
                        widx_b_reg              <= advance(widx_b_reg);
                    end
                    srqe_pkg::CMD_SAMPLE_C:
                    begin
                        valid_c_reg[widx_c_reg] <= 1'b1;
                        widx_c_reg              <= advance(widx_c_reg);
                    end
                    default: ;
                endcase
            end
            if (cmd.rd_newest || cmd.rd_walk)
            begin
                rvalid_a_reg <= valid_a_reg[rd_addr];
                rvalid_b_reg <= valid_b_reg[rd_addr];
                rvalid_c_reg <= valid_c_reg[rd_addr];
            end
        end
    end

    // request, accumulator, divider, result
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            code_reg  <= code_in;
            known_reg <= known_in;
            mean_reg  <= mean_in;
            sel_reg   <= srqe_pkg::ring_sel_t'(sel_off[1:0]);
            sum_reg   <= 32'd0;
            cnt_reg   <= '0;
        end
        else if (cmd.acc)
        begin
            sum_reg <= sum_reg + rd_value;
            cnt_reg <= cnt_reg + srqe_pkg::CNT_W'(1);
        end
        if (cmd.div_load)
        begin
            quo_reg  <= sum_reg;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg  <= {quo_reg[30:0], fits};
            rem_reg  <= fits ? srqe_pkg::CNT_W'(rem_sh - {1'b0, cnt_reg})
                             : rem_sh[srqe_pkg::CNT_W-1:0];
            step_reg <= step_reg + srqe_pkg::STEP_W'(1);
        end
        if (cmd.out_load)
        begin
            rsp_reg.echoed_code   <= code_reg;
            rsp_reg.known_request <= known_reg;
            case (cmd.out_src)
                srqe_pkg::SRC_NEWEST: rsp_reg.payload <= rd_value;
                srqe_pkg::SRC_QUOT:   rsp_reg.payload <= quo_reg;
                default:              rsp_reg.payload <= 32'd0;
            endcase
        end
    end

    assign status.known    = known_reg;
    assign status.is_mean  = mean_reg;
    assign status.rd_zero  = (rd_value == 32'd0);
    assign status.cnt_zero = (cnt_reg == '0);
    assign status.cnt_last = (cnt_reg == srqe_pkg::CNT_W'(srqe_pkg::RING_DEPTH - 1));
    assign status.div_last = (step_reg == srqe_pkg::STEP_W'(srqe_pkg::DIV_STEPS - 1));
    assign rsp_word        = rsp_reg;

endmodule

// ===== design/srqe_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srqe_controller
// Sequencer for sample writes, ring reads, mean walk, division and handoff.
// ----------------------------------------------------------------------------
module srqe_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_is_request,
    output logic                 req_stall,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output srqe_pkg::ctl_cmd_t   cmd,
    input  srqe_pkg::dp_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOAD_NEW,
        ST_CHECK,
        ST_READ,
        ST_DIV_LOAD,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic {
        PH_WORK,
        PH_OUT
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   req_stall_reg, req_stall_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        req_stall_next = req_stall_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd            = '0;
        cmd.out_src    = srqe_pkg::SRC_ZERO;

        if (phase_reg == PH_OUT)
        begin
            if (!rsp_stall)
            begin
                phase_next     = PH_WORK;
                state_next     = ST_IDLE;
                rsp_valid_next = 1'b0;
                req_stall_next = 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        if (req_is_request)
                        begin
                            cmd.load_req   = 1'b1;
                            state_next     = ST_DECODE;
                            req_stall_next = 1'b1;
                        end
                        else
                            cmd.sample_wr = 1'b1;
                    end
                end
                ST_DECODE:
                begin
                    if (!status.known)
                    begin
                        cmd.out_load   = 1'b1;
                        phase_next     = PH_OUT;
                        rsp_valid_next = 1'b1;
                    end
                    else if (status.is_mean)
                    begin
                        cmd.rd_walk = 1'b1;
                        state_next  = ST_CHECK;
                    end
                    else
                    begin
                        cmd.rd_newest = 1'b1;
                        state_next    = ST_LOAD_NEW;
                    end
                end
                ST_LOAD_NEW:
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_src    = srqe_pkg::SRC_NEWEST;
                    phase_next     = PH_OUT;
                    rsp_valid_next = 1'b1;
                end
                ST_CHECK:
                begin
                    if (!status.rd_zero)
                    begin
                        cmd.acc    = 1'b1;
                        state_next = status.cnt_last ? ST_DIV_LOAD : ST_READ;
                    end
                    else if (status.cnt_zero)
                    begin
                        cmd.out_load   = 1'b1;
                        phase_next     = PH_OUT;
                        rsp_valid_next = 1'b1;
                    end
                    else
                        state_next = ST_DIV_LOAD;
                end
                ST_READ:
                begin
                    cmd.rd_walk = 1'b1;
                    state_next  = ST_CHECK;
                end
                ST_DIV_LOAD:
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV;
                end
                ST_DIV:
                begin
                    cmd.div_step = 1'b1;
                    if (status.div_last)
                        state_next = ST_FINISH;
                end
                ST_FINISH:
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_src    = srqe_pkg::SRC_QUOT;
                    phase_next     = PH_OUT;
                    rsp_valid_next = 1'b1;
                end
                default:
                begin
                    state_next     = ST_IDLE;
                    req_stall_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_WORK;
            req_stall_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            req_stall_reg <= req_stall_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = req_stall_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor ring query engine: a queue-fed driver
// offers sample and request words, a monitor keeps a model of the three
// rings, predicts each reply and compares it field by field with the DUT.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int LONG_HOLD      = 300;
    localparam int LONG_HOLD_AT   = 120;
    localparam int RANDOM_WORDS   = 400;

    localparam logic [7:0] CODE_ZERO_BYTE = 8'h00;
    localparam logic [7:0] CODE_ALL_ONES  = 8'hFF;
    localparam logic [7:0] CODE_PAST_LAST = 8'hA6;
    localparam logic [7:0] CODE_BELOW     = 8'h9F;

    typedef struct {
        srqe_pkg::req_word_t word;
        int                  phase;
        bit                  drain;
    } stim_item_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    srqe_pkg::req_word_t req_word;
    logic                rsp_valid;
    logic                rsp_stall;
    srqe_pkg::rsp_word_t rsp_word;

    stim_item_t          pending_words[$];
    srqe_pkg::rsp_word_t expected_replies[$];
    logic [31:0]         ring_model[3][srqe_pkg::RING_DEPTH];
    int                  wr_ptr[3];
    int                  send_idle_pct[3] = '{37, 66, 0};
    int                  recv_idle_pct[3] = '{66, 37, 0};
    int                  driven_phase;
    int                  words_taken;
    int                  mismatch_count;
    bit                  req_fired;
    bit                  rsp_fired;

    logic [7:0] known_codes[6] = '{srqe_pkg::CODE_NEWEST_A, srqe_pkg::CODE_NEWEST_B,
                                   srqe_pkg::CODE_NEWEST_C, srqe_pkg::CODE_MEAN_A,
                                   srqe_pkg::CODE_MEAN_B, srqe_pkg::CODE_MEAN_C};

    sensor_ring_query_engine_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int latest_slot(int ptr);
        return (ptr == 0) ? srqe_pkg::RING_DEPTH - 1 : ptr - 1;
    endfunction

    function automatic logic [31:0] leading_mean(int ring);
        logic [31:0] total;
        int          n;
        total = '0;
        n     = 0;
        while (n < srqe_pkg::RING_DEPTH && ring_model[ring][n] != 32'd0)
        begin
            total += ring_model[ring][n];
            n++;
        end
        return (n == 0) ? 32'd0 : total / 32'(n);
    endfunction

    function automatic srqe_pkg::rsp_word_t answer_request(logic [7:0] code);
        srqe_pkg::rsp_word_t r;
        int                  ra;
        int                  rb;
        int                  rc;
        ra              = srqe_pkg::RING_A;
        rb              = srqe_pkg::RING_B;
        rc              = srqe_pkg::RING_C;
        r.echoed_code   = code;
        r.payload       = '0;
        r.known_request = 1'b1;
        case (code)
            srqe_pkg::CODE_NEWEST_A: r.payload = ring_model[ra][latest_slot(wr_ptr[ra])];
            srqe_pkg::CODE_NEWEST_B: r.payload = ring_model[rb][latest_slot(wr_ptr[rb])];
            srqe_pkg::CODE_NEWEST_C: r.payload = ring_model[rc][latest_slot(wr_ptr[rc])];
            srqe_pkg::CODE_MEAN_A:   r.payload = leading_mean(ra);
            srqe_pkg::CODE_MEAN_B:   r.payload = leading_mean(rb);
            srqe_pkg::CODE_MEAN_C:   r.payload = leading_mean(rc);
            default:                 r.known_request = 1'b0;
        endcase
        return r;
    endfunction

    function automatic void store_sample(srqe_pkg::command_t cmd, logic [31:0] value);
        int ring;
        case (cmd)
            srqe_pkg::CMD_SAMPLE_A: ring = srqe_pkg::RING_A;
            srqe_pkg::CMD_SAMPLE_B: ring = srqe_pkg::RING_B;
            default:                ring = srqe_pkg::RING_C;
        endcase
        ring_model[ring][wr_ptr[ring]] = (cmd == srqe_pkg::CMD_SAMPLE_C) ? value
                                                                         : {24'd0, value[7:0]};
        wr_ptr[ring] = (wr_ptr[ring] == srqe_pkg::RING_DEPTH - 1) ? 0 : wr_ptr[ring] + 1;
    endfunction

    function automatic void queue_word(srqe_pkg::command_t cmd, logic [31:0] value,
                                       logic [7:0] code, int phase, bit drain);
        stim_item_t item;
        item.word.command      = cmd;
        item.word.sample_value = value;
        item.word.request_code = code;
        item.phase             = phase;
        item.drain             = drain;
        pending_words.push_back(item);
    endfunction

    task automatic check_reply(srqe_pkg::rsp_word_t got);
        srqe_pkg::rsp_word_t want;
        if (expected_replies.size() == 0)
        begin
            $error("reply with nothing outstanding: code %0h payload %0h",
                   got.echoed_code, got.payload);
            mismatch_count++;
        end
        else
        begin
            want = expected_replies.pop_front();
            if (got.echoed_code !== want.echoed_code)
            begin
                $error("echoed_code expected %0h actual %0h", want.echoed_code, got.echoed_code);
                mismatch_count++;
            end
            if (got.payload !== want.payload)
            begin
                $error("payload expected %0h actual %0h", want.payload, got.payload);
                mismatch_count++;
            end
            if (got.known_request !== want.known_request)
            begin
                $error("known_request expected %0b actual %0b",
                       want.known_request, got.known_request);
                mismatch_count++;
            end
        end
    endtask

    // request side: hold a stalled word, otherwise pick the next one or idle
    always @(negedge clk)
    begin
        stim_item_t head;
        bit         hold_word;
        bit         send_now;
        hold_word = req_valid && !req_fired;
        send_now  = 1'b0;
        if (rst_n && !hold_word && pending_words.size() > 0)
        begin
            head = pending_words[0];
            if (head.drain && expected_replies.size() > 0)
                send_now = 1'b0;
            else if ($urandom_range(99) < send_idle_pct[head.phase])
                send_now = 1'b0;
            else
                send_now = 1'b1;
            if (send_now)
                void'(pending_words.pop_front());
        end
        if (!hold_word)
        begin
            req_valid <= send_now;
            if (send_now)
            begin
                req_word     <= head.word;
                driven_phase <= head.phase;
            end
        end
    end

    // reply side: one long hold-off, otherwise random stalls
    always @(negedge clk)
    begin
        static int hold_left = 0;
        static bit hold_done = 1'b0;
        logic      stall_next;
        if (!hold_done && words_taken >= LONG_HOLD_AT)
        begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            stall_next = 1'b1;
            hold_left--;
        end
        else
            stall_next = ($urandom_range(99) < recv_idle_pct[driven_phase]);
        rsp_stall <= stall_next;
    end

    always @(posedge clk)
    begin
        req_fired = 1'b0;
        rsp_fired = 1'b0;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                req_fired = 1'b1;
                words_taken++;
                if (srqe_pkg::command_t'(req_word.command) == srqe_pkg::CMD_REQUEST)
                    expected_replies.push_back(answer_request(req_word.request_code));
                else
                    store_sample(srqe_pkg::command_t'(req_word.command), req_word.sample_value);
            end
            if (rsp_valid && !rsp_stall)
            begin
                rsp_fired = 1'b1;
                check_reply(rsp_word);
            end
        end
    end

    always @(posedge clk)
    begin
        static int quiet_cycles = 0;
        if (req_fired || rsp_fired || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        srqe_pkg::command_t cmd;
        logic [31:0]        value;
        logic [7:0]         code;
        int                 phase;
        req_valid      = 1'b0;
        req_word       = '0;
        rsp_stall      = 1'b0;
        rst_n          = 1'b0;
        driven_phase   = 0;
        words_taken    = 0;
        mismatch_count = 0;
        for (int r = 0; r < 3; r++)
        begin
            wr_ptr[r] = 0;
            for (int i = 0; i < srqe_pkg::RING_DEPTH; i++)
                ring_model[r][i] = '0;
        end

        // empty rings: newest from the last index, empty mean
        queue_word(srqe_pkg::CMD_REQUEST, 32'hFFFF_FFFF, srqe_pkg::CODE_NEWEST_A, 0, 1'b0);
        queue_word(srqe_pkg::CMD_REQUEST, 32'h0, srqe_pkg::CODE_MEAN_A, 0, 1'b0);
        queue_word(srqe_pkg::CMD_REQUEST, 32'h0, srqe_pkg::CODE_MEAN_C, 0, 1'b0);
        // unknown codes
        queue_word(srqe_pkg::CMD_REQUEST, 32'hDEAD_BEEF, CODE_ZERO_BYTE, 0, 1'b0);
        queue_word(srqe_pkg::CMD_REQUEST, 32'h0, CODE_ALL_ONES, 0, 1'b0);
        queue_word(srqe_pkg::CMD_REQUEST, 32'h0, CODE_PAST_LAST, 0, 1'b0);
        queue_word(srqe_pkg::CMD_REQUEST, 32'h0, CODE_BELOW, 0, 1'b0);
        // wrapping C sum
        queue_word(srqe_pkg::CMD_SAMPLE_C, 32'hFFFF_FFFF, CODE_ALL_ONES, 0, 1'b0);
        queue_word(srqe_pkg::CMD_SAMPLE_C, 32'h8000_0001, srqe_pkg::CODE_MEAN_C, 0, 1'b0);
        queue_word(srqe_pkg::CMD_REQUEST, 32'h0, srqe_pkg::CODE_MEAN_C, 0, 1'b0);
        queue_word(srqe_pkg::CMD_REQUEST, 32'h0, srqe_pkg::CODE_NEWEST_C, 0, 1'b0);
        // zero sample after dropping upper bits
        queue_word(srqe_pkg::CMD_SAMPLE_B, 32'hFFFF_FF00, CODE_ZERO_BYTE, 0, 1'b0);
        queue_word(srqe_pkg::CMD_REQUEST, 32'h0, srqe_pkg::CODE_MEAN_B, 0, 1'b0);
        queue_word(srqe_pkg::CMD_REQUEST, 32'h0, srqe_pkg::CODE_NEWEST_B, 0, 1'b0);
        // fill A until the index wraps to zero
        for (int i = 0; i < srqe_pkg::RING_DEPTH; i++)
            queue_word(srqe_pkg::CMD_SAMPLE_A, 32'h1234_56FF, 8'($urandom()), 0, 1'b0);
        queue_word(srqe_pkg::CMD_REQUEST, 32'h0, srqe_pkg::CODE_NEWEST_A, 0, 1'b0);
        queue_word(srqe_pkg::CMD_REQUEST, 32'h0, srqe_pkg::CODE_MEAN_A, 0, 1'b0);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            phase = (n * 3) / RANDOM_WORDS;
            cmd   = ($urandom_range(99) < 35) ? srqe_pkg::CMD_REQUEST
                                              : srqe_pkg::command_t'($urandom_range(2));
            case ($urandom_range(15))
                0:       value = 32'd0;
                1, 2, 3: value = $urandom_range(255);
                4:       value = 32'hFFFF_FFFF;
                5:       value = 32'hF000_0000 | $urandom();
                default: value = $urandom();
            endcase
            if ($urandom_range(3) == 0)
                code = 8'($urandom());
            else
                code = known_codes[$urandom_range(5)];
            queue_word(cmd, value, code, phase,
                       (n == RANDOM_WORDS / 3) || ($urandom_range(49) == 0));
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() > 0 || req_valid || expected_replies.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sensor_ring_query_engine_unit.f =====
design/srqe_pkg.sv
design/srqe_datapath.sv
design/srqe_controller.sv
design/sensor_ring_query_engine_unit.sv
bench/tb_top.sv
